// File: rtl/core/dncp_packet_field_extractor_assert.svh
// assertion macros for the dncp field extractor checker
// used by dncp_pfx_checker; needs nothing else
`ifndef DNCP_PACKET_FIELD_EXTRACTOR_ASSERT_SVH
`define DNCP_PACKET_FIELD_EXTRACTOR_ASSERT_SVH

// generic clocked property, off during reset
`define DPFX_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("dncp field extractor: assertion failed");

// signal holds in the cycle after cond
`define DPFX_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
	else $error("dncp field extractor: value changed while held");

`endif

// File: rtl/core/dncp_pfx_pkg.sv
// shared types and constants of the dncp packet field extractor
// no dependencies
`default_nettype none

package dncp_pfx_pkg;

	localparam int MAX_PACKET = 2048;
	localparam int POS_W = $clog2(MAX_PACKET + 1);
	// byte offset within a registry entry, counts up to 40
	localparam int EP_W = 6;

	localparam logic [15:0] MSG_REGISTRY = 16'h0100;
	localparam logic [15:0] MSG_ANNOUNCE = 16'h0200;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_NODE    = 3'd1,
		KIND_PLCA    = 3'd2,
		KIND_REGHDR  = 3'd3,
		KIND_ENTRY   = 3'd4,
		KIND_END     = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        last;
		logic [47:0] mac;
		logic [63:0] dev_id;
		logic [31:0] ipv4;
		logic [7:0]  state;
		logic        pers;
		logic [15:0] msg_id;
		logic [7:0]  msg_type;
		logic [7:0]  ver;
		logic [15:0] count;
		logic [7:0]  index;
	} rec_t;

	// records caused by one byte: an optional data record, an optional end record
	typedef struct packed {
		logic dv;
		logic ev;
		rec_t dr;
		rec_t er;
	} rec_pair_t;

endpackage

`default_nettype wire

// File: rtl/core/dncp_pfx_parse.sv
// per-packet parse state and record build for one byte
// depends on dncp_pfx_pkg
`default_nettype none

module dncp_pfx_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_in,
	input  logic                   eop_in,
	output dncp_pfx_pkg::rec_pair_t pair
);
	import dncp_pfx_pkg::*;

	logic [POS_W-1:0] pos_q, pos_n;
	logic             hdr_q, hdr_n;
	logic [7:0]       hs_q [16];
	logic [47:0]      mac_q, mac_n;
	logic [63:0]      id_q, id_n;
	logic [31:0]      ip_q, ip_n;
	logic [7:0]       state_q, state_n;
	logic             pers_q, pers_n;
	logic [7:0]       slot_cnt_q, slot_cnt_n;
	logic [7:0]       slot_idx_q, slot_idx_n;
	logic [EP_W-1:0]  epos_q, epos_n;
	logic [7:0]       left_q, left_n;
	logic [7:0]       enum_q, enum_n;

	logic             hs_we;
	logic [3:0]       hs_wa;
	logic [15:0]      msg;
	logic [POS_W-1:0] p;
	logic [EP_W-1:0]  e;
	rec_t             dr, er;
	logic             dv, ev;

	always_comb begin
		p = pos_q;
		e = epos_q;
		msg = {hs_q[12], hs_q[13]};
		pos_n = pos_q;
		hdr_n = hdr_q;
		mac_n = mac_q;
		id_n = id_q;
		ip_n = ip_q;
		state_n = state_q;
		pers_n = pers_q;
		slot_cnt_n = slot_cnt_q;
		slot_idx_n = slot_idx_q;
		epos_n = epos_q;
		left_n = left_q;
		enum_n = enum_q;
		hs_we = 1'b0;
		hs_wa = p[3:0];
		dv = 1'b0;
		dr = '0;
		er = '0;

		if (p < POS_W'(MAX_PACKET)) begin
			pos_n = p + POS_W'(1);
			if (p < POS_W'(16)) begin
				hs_we = 1'b1;
				if (p == POS_W'(15)) begin
					dv = 1'b1;
					dr.kind = KIND_HEADER;
					dr.mac = {hs_q[4], hs_q[5], hs_q[6], hs_q[7], hs_q[8], hs_q[9]};
					dr.msg_id = {hs_q[12], hs_q[13]};
					dr.msg_type = hs_q[11];
					dr.ver = hs_q[10];
					dr.count = {hs_q[14], data_in};
					hdr_n = 1'b1;
				end
			end else if (msg == MSG_ANNOUNCE) begin
				if (p >= POS_W'(18) && p <= POS_W'(23)) begin
					mac_n = {mac_q[39:0], data_in};
				end else if (p >= POS_W'(24) && p <= POS_W'(31)) begin
					id_n = {id_q[55:0], data_in};
				end else if (p >= POS_W'(48) && p <= POS_W'(51)) begin
					ip_n = {ip_q[23:0], data_in};
				end else if (p == POS_W'(52)) begin
					pers_n = (data_in != 8'd0);
				end else if (p == POS_W'(53)) begin
					state_n = data_in;
				end else if (p == POS_W'(55)) begin
					slot_cnt_n = data_in;
					slot_idx_n = 8'd0;
					dv = 1'b1;
					dr.kind = KIND_NODE;
					dr.mac = mac_q;
					dr.dev_id = id_q;
					dr.ipv4 = ip_q;
					dr.state = state_q;
					dr.pers = pers_q;
					dr.count = {8'd0, data_in};
				end else if (p >= POS_W'(56) && slot_idx_q < slot_cnt_q) begin
					dv = 1'b1;
					dr.kind = KIND_PLCA;
					dr.index = data_in;
					slot_idx_n = slot_idx_q + 8'd1;
				end
			end else if (msg == MSG_REGISTRY) begin
				if (p == POS_W'(16)) begin
					hs_we = 1'b1;
					hs_wa = 4'd0;
				end else if (p == POS_W'(17)) begin
					hs_we = 1'b1;
					hs_wa = 4'd1;
				end else if (p == POS_W'(18)) begin
					left_n = data_in;
					enum_n = 8'd0;
					epos_n = '0;
					slot_idx_n = 8'd0;
					dv = 1'b1;
					dr.kind = KIND_REGHDR;
					dr.ver = hs_q[0];
					dr.count = {8'd0, hs_q[1]};
					dr.index = data_in;
				end else if (left_q != 8'd0) begin
					if (slot_idx_q != 8'd0) begin
						// skipping the slot bytes that trail an entry
						slot_idx_n = slot_idx_q - 8'd1;
						if (slot_idx_q == 8'd1) begin
							left_n = left_q - 8'd1;
							enum_n = enum_q + 8'd1;
							epos_n = '0;
						end
					end else begin
						if (e >= EP_W'(2) && e <= EP_W'(7)) begin
							mac_n = {mac_q[39:0], data_in};
						end else if (e >= EP_W'(8) && e <= EP_W'(15)) begin
							id_n = {id_q[55:0], data_in};
						end else if (e >= EP_W'(32) && e <= EP_W'(35)) begin
							ip_n = {ip_q[23:0], data_in};
						end else if (e == EP_W'(36)) begin
							state_n = data_in;
						end
						if (e == EP_W'(39)) begin
							dv = 1'b1;
							dr.kind = KIND_ENTRY;
							dr.mac = mac_q;
							dr.dev_id = id_q;
							dr.ipv4 = ip_q;
							dr.state = state_q;
							dr.index = enum_q;
							slot_cnt_n = data_in;
							if (data_in == 8'd0) begin
								left_n = left_q - 8'd1;
								enum_n = enum_q + 8'd1;
								epos_n = '0;
							end else begin
								slot_idx_n = data_in;
								epos_n = EP_W'(40);
							end
						end else begin
							epos_n = e + EP_W'(1);
						end
					end
				end
			end
		end

		ev = eop_in && hdr_n;
		er.kind = KIND_END;
		er.last = 1'b1;
		er.count = 16'(pos_n);
		dr.last = !ev;

		if (eop_in) begin
			pos_n = '0;
			hdr_n = 1'b0;
			mac_n = '0;
			id_n = '0;
			ip_n = '0;
			state_n = '0;
			pers_n = 1'b0;
			slot_cnt_n = '0;
			slot_idx_n = '0;
			epos_n = '0;
			left_n = '0;
			enum_n = '0;
		end

		pair.dv = dv;
		pair.ev = ev;
		pair.dr = dr;
		pair.er = er;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= 1'b0;
			mac_q <= '0;
			id_q <= '0;
			ip_q <= '0;
			state_q <= '0;
			pers_q <= 1'b0;
			slot_cnt_q <= '0;
			slot_idx_q <= '0;
			epos_q <= '0;
			left_q <= '0;
			enum_q <= '0;
		end else if (step) begin
			pos_q <= pos_n;
			hdr_q <= hdr_n;
			mac_q <= mac_n;
			id_q <= id_n;
			ip_q <= ip_n;
			state_q <= state_n;
			pers_q <= pers_n;
			slot_cnt_q <= slot_cnt_n;
			slot_idx_q <= slot_idx_n;
			epos_q <= epos_n;
			left_q <= left_n;
			enum_q <= enum_n;
		end
	end

	// header bytes, every entry written before it is read within a packet
	always_ff @(posedge clk) begin
		if (step && hs_we) begin
			hs_q[hs_wa] <= data_in;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dncp_pfx_outbuf.sv
// two-record result register that hands records out one per request
// depends on dncp_pfx_pkg
`default_nettype none

module dncp_pfx_outbuf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  dncp_pfx_pkg::rec_pair_t pair,
	input  logic                    out_ready,
	output logic                    out_valid,
	output dncp_pfx_pkg::rec_t      head,
	output logic                    can_load
);
	import dncp_pfx_pkg::*;

	logic [1:0] n_q;
	rec_t       rec0_s2, rec1_s2;
	logic       take;

	assign out_valid = (n_q != 2'd0);
	assign head = rec0_s2;
	assign take = out_valid && out_ready;
	// room once the current contents are gone by the end of this cycle
	assign can_load = (n_q == 2'd0) || (n_q == 2'd1 && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
		end else if (load) begin
			n_q <= {1'b0, pair.dv} + {1'b0, pair.ev};
		end else if (take) begin
			n_q <= n_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec0_s2 <= pair.dv ? pair.dr : pair.er;
			rec1_s2 <= pair.er;
		end else if (take && n_q == 2'd2) begin
			rec0_s2 <= rec1_s2;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dncp_packet_field_extractor.sv
// top level of the dncp packet field extractor
// depends on dncp_pfx_pkg, dncp_pfx_parse, dncp_pfx_outbuf
//
// Usage:
// - input channel in_valid/in_ready carries one payload byte per request
//   (data_byte) and end_of_packet on the final byte of a datagram
// - output channel out_valid/out_ready carries one record per request;
//   last_result marks the final record caused by a given byte
// - a byte waits in the input register until the result register has room,
//   then is parsed into the result register, from which its first record
//   shows on out_valid
// - throughput is one byte per cycle while out_ready stays high; a byte
//   that causes two records (a record plus the packet end record) holds the
//   input while the second record is handed out
// - when the receiver stalls, at most two records wait in the result
//   register and one byte in the input register, then in_ready drops
// - reset clears the parse state; the first byte after reset starts a packet
`default_nettype none

module dncp_packet_field_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  record_kind,
	output logic        last_result,
	output logic [47:0] mac_address,
	output logic [63:0] device_identifier,
	output logic [31:0] ipv4_address,
	output logic [7:0]  node_state,
	output logic        persistent,
	output logic [15:0] message_id,
	output logic [7:0]  message_type,
	output logic [7:0]  version_or_channel,
	output logic [15:0] count_value,
	output logic [7:0]  index_value
);
	import dncp_pfx_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eop_s1;
	logic       can_load;
	logic       consume;
	rec_pair_t  pair;
	rec_t       head;

	assign consume = valid_s1 && can_load;
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eop_s1 <= end_of_packet;
		end
	end

	dncp_pfx_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (consume),
		.data_in (byte_s1),
		.eop_in  (eop_s1),
		.pair    (pair)
	);

	dncp_pfx_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume),
		.pair      (pair),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.can_load  (can_load)
	);

	assign record_kind = head.kind;
	assign last_result = head.last;
	assign mac_address = head.mac;
	assign device_identifier = head.dev_id;
	assign ipv4_address = head.ipv4;
	assign node_state = head.state;
	assign persistent = head.pers;
	assign message_id = head.msg_id;
	assign message_type = head.msg_type;
	assign version_or_channel = head.ver;
	assign count_value = head.count;
	assign index_value = head.index;

endmodule

`default_nettype wire

// File: rtl/core/dncp_pfx_checker.sv
// port-level checks for the dncp packet field extractor, bound to the top
// depends on dncp_pfx_pkg and dncp_packet_field_extractor_assert.svh
`default_nettype none

`include "dncp_packet_field_extractor_assert.svh"

module dncp_pfx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  record_kind,
	input logic        last_result,
	input logic [47:0] mac_address,
	input logic [7:0]  index_value
);
	import dncp_pfx_pkg::*;

	`DPFX_ASSERT_HOLD(a_kind_hold, clk, arst_n, out_valid && !out_ready, record_kind)
	`DPFX_ASSERT(a_kind_range, clk, arst_n, out_valid |-> (record_kind != 3'd6 && record_kind != 3'd7))
	// only a packet end record can follow another record of the same byte
	`DPFX_ASSERT(a_second_is_end, clk, arst_n, out_valid && out_ready && !last_result |=> out_valid && record_kind == KIND_END && last_result)
	`DPFX_ASSERT(a_end_is_last, clk, arst_n, out_valid && record_kind == KIND_END |-> last_result && mac_address == 48'd0 && index_value == 8'd0)

endmodule

bind dncp_packet_field_extractor dncp_pfx_checker u_dncp_pfx_checker (.*);

`default_nettype wire

// File: tb/sv/dncp_packet_field_extractor_tb.sv
// testbench for the dncp packet field extractor: directed and random packets
// are streamed in, and every record is checked against a built-in field parser
// depends on dncp_pfx_pkg and dncp_packet_field_extractor

module dncp_packet_field_extractor_tb;
	import dncp_pfx_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 740;

	typedef struct packed {
		kind_t       kind;
		bit          fin;
		bit [47:0]   mac;
		bit [63:0]   dev;
		bit [31:0]   ip;
		bit [7:0]    st;
		bit          pers;
		bit [15:0]   id;
		bit [7:0]    mtype;
		bit [7:0]    ver;
		bit [15:0]   cnt;
		bit [7:0]    idx;
	} field_rec_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_packet = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  record_kind;
	logic        last_result;
	logic [47:0] mac_address;
	logic [63:0] device_identifier;
	logic [31:0] ipv4_address;
	logic [7:0]  node_state;
	logic        persistent;
	logic [15:0] message_id;
	logic [7:0]  message_type;
	logic [7:0]  version_or_channel;
	logic [15:0] count_value;
	logic [7:0]  index_value;

	dncp_packet_field_extractor u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.data_byte          (data_byte),
		.end_of_packet      (end_of_packet),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.record_kind        (record_kind),
		.last_result        (last_result),
		.mac_address        (mac_address),
		.device_identifier  (device_identifier),
		.ipv4_address       (ipv4_address),
		.node_state         (node_state),
		.persistent         (persistent),
		.message_id         (message_id),
		.message_type       (message_type),
		.version_or_channel (version_or_channel),
		.count_value        (count_value),
		.index_value        (index_value)
	);

	// parser state, mirrors the per-packet state of the block
	int unsigned rx_pos;
	bit          hdr_seen;
	bit [7:0]    hdr_bytes [16];
	bit [63:0]   dev_acc;
	bit [47:0]   mac_acc;
	bit [31:0]   ip_acc;
	bit [7:0]    state_acc;
	bit          pers_acc;
	bit [7:0]    slot_total;
	bit [7:0]    slot_tally;
	int unsigned entry_off;
	bit [7:0]    entries_todo;
	bit [7:0]    entry_idx;

	field_rec_t  records_due [$];
	bit [7:0]    pkt [$];

	int  mismatch_count = 0;
	int  records_checked = 0;
	int  kind_seen [6];
	int  bytes_sent = 0;
	int  packets_sent = 0;
	int  cycle_count = 0;
	int  stall_left = 0;
	bit  rx_gaps = 1'b0;
	bit  tx_gaps = 1'b0;
	bit  quiet_tail = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void restart_packet();
		rx_pos = 0;
		hdr_seen = 1'b0;
		dev_acc = '0;
		mac_acc = '0;
		ip_acc = '0;
		state_acc = '0;
		pers_acc = 1'b0;
		slot_total = '0;
		slot_tally = '0;
		entry_off = 0;
		entries_todo = '0;
		entry_idx = '0;
	endfunction

	function automatic field_rec_t blank_record(input kind_t k);
		field_rec_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic void announce_byte(input int unsigned p, input bit [7:0] b,
		ref field_rec_t made [$]);
		field_rec_t r;
		if (p >= 18 && p <= 23) mac_acc = {mac_acc[39:0], b};
		else if (p >= 24 && p <= 31) dev_acc = {dev_acc[55:0], b};
		else if (p >= 48 && p <= 51) ip_acc = {ip_acc[23:0], b};
		else if (p == 52) pers_acc = (b != 0);
		else if (p == 53) state_acc = b;
		else if (p == 55) begin
			slot_total = b;
			slot_tally = 0;
			r = blank_record(KIND_NODE);
			r.mac = mac_acc;
			r.dev = dev_acc;
			r.ip = ip_acc;
			r.st = state_acc;
			r.pers = pers_acc;
			r.cnt = {8'h00, b};
			made.push_back(r);
		end else if (p >= 56 && slot_tally < slot_total) begin
			r = blank_record(KIND_PLCA);
			r.idx = b;
			made.push_back(r);
			slot_tally++;
		end
	endfunction

	function automatic void registry_byte(input int unsigned p, input bit [7:0] b,
		ref field_rec_t made [$]);
		field_rec_t r;
		if (p == 16) hdr_bytes[0] = b;
		else if (p == 17) hdr_bytes[1] = b;
		else if (p == 18) begin
			entries_todo = b;
			entry_idx = 0;
			entry_off = 0;
			slot_tally = 0;
			r = blank_record(KIND_REGHDR);
			r.ver = hdr_bytes[0];
			r.cnt = {8'h00, hdr_bytes[1]};
			r.idx = b;
			made.push_back(r);
		end else if (p >= 19 && entries_todo != 0) begin
			if (slot_tally != 0) begin
				// skipping the slot bytes that trail an entry
				slot_tally--;
				if (slot_tally == 0) begin
					entries_todo--;
					entry_idx++;
					entry_off = 0;
				end
			end else begin
				if (entry_off >= 2 && entry_off <= 7) mac_acc = {mac_acc[39:0], b};
				else if (entry_off >= 8 && entry_off <= 15) dev_acc = {dev_acc[55:0], b};
				else if (entry_off >= 32 && entry_off <= 35) ip_acc = {ip_acc[23:0], b};
				else if (entry_off == 36) state_acc = b;
				if (entry_off == 39) begin
					r = blank_record(KIND_ENTRY);
					r.mac = mac_acc;
					r.dev = dev_acc;
					r.ip = ip_acc;
					r.st = state_acc;
					r.idx = entry_idx;
					made.push_back(r);
					slot_total = b;
					if (b == 0) begin
						entries_todo--;
						entry_idx++;
						entry_off = 0;
					end else begin
						slot_tally = b;
						entry_off = 40;
					end
				end else begin
					entry_off++;
				end
			end
		end
	endfunction

	// works out the records one accepted byte causes and queues them
	function automatic void extract_fields(input bit [7:0] b, input bit eop);
		field_rec_t made [$];
		field_rec_t r;
		bit [15:0] msg;
		int unsigned p;
		p = rx_pos;
		if (p < MAX_PACKET) begin
			if (p < 16) begin
				hdr_bytes[p] = b;
				if (p == 15) begin
					r = blank_record(KIND_HEADER);
					r.mac = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6],
						hdr_bytes[7], hdr_bytes[8], hdr_bytes[9]};
					r.id = {hdr_bytes[12], hdr_bytes[13]};
					r.mtype = hdr_bytes[11];
					r.ver = hdr_bytes[10];
					r.cnt = {hdr_bytes[14], hdr_bytes[15]};
					made.push_back(r);
					hdr_seen = 1'b1;
				end
			end else begin
				msg = {hdr_bytes[12], hdr_bytes[13]};
				if (msg == MSG_ANNOUNCE) announce_byte(p, b, made);
				else if (msg == MSG_REGISTRY) registry_byte(p, b, made);
			end
			rx_pos = p + 1;
		end
		if (eop) begin
			if (hdr_seen) begin
				r = blank_record(KIND_END);
				r.cnt = rx_pos[15:0];
				made.push_back(r);
			end
			restart_packet();
		end
		if (made.size() > 0) made[made.size() - 1].fin = 1'b1;
		foreach (made[i]) records_due.push_back(made[i]);
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatch_count < 60)
			$display("mismatch at record %0d: %s got %0h want %0h",
				records_checked, field, got, want);
		mismatch_count++;
	endtask

	task automatic check_record(input field_rec_t w);
		if (record_kind !== w.kind)
			report_mismatch("record_kind", 64'(record_kind), 64'(w.kind));
		if (last_result !== w.fin)
			report_mismatch("last_result", 64'(last_result), 64'(w.fin));
		if (mac_address !== w.mac)
			report_mismatch("mac_address", 64'(mac_address), 64'(w.mac));
		if (device_identifier !== w.dev)
			report_mismatch("device_identifier", device_identifier, w.dev);
		if (ipv4_address !== w.ip)
			report_mismatch("ipv4_address", 64'(ipv4_address), 64'(w.ip));
		if (node_state !== w.st)
			report_mismatch("node_state", 64'(node_state), 64'(w.st));
		if (persistent !== w.pers)
			report_mismatch("persistent", 64'(persistent), 64'(w.pers));
		if (message_id !== w.id)
			report_mismatch("message_id", 64'(message_id), 64'(w.id));
		if (message_type !== w.mtype)
			report_mismatch("message_type", 64'(message_type), 64'(w.mtype));
		if (version_or_channel !== w.ver)
			report_mismatch("version_or_channel", 64'(version_or_channel), 64'(w.ver));
		if (count_value !== w.cnt)
			report_mismatch("count_value", 64'(count_value), 64'(w.cnt));
		if (index_value !== w.idx)
			report_mismatch("index_value", 64'(index_value), 64'(w.idx));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (records_due.size() == 0) begin
				report_mismatch("unexpected record, kind", 64'(record_kind), 64'd0);
			end else begin
				check_record(records_due[0]);
				if (records_due[0].kind < 6) kind_seen[records_due[0].kind]++;
				void'(records_due.pop_front());
			end
			records_checked++;
		end
	end

	// cycle count, run limit and receiver stalls
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records outstanding",
				cycle_count, records_due.size());
			$display("end of test: mismatches");
			$finish;
		end
		if (cycle_count % 128 == 0) rx_gaps = ($urandom_range(0, 3) != 0);
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (rx_gaps && !quiet_tail && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// valid stays high after a request unless a gap or a pause follows
	task automatic send_item(input bit [7:0] b, input bit eop);
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_packet <= eop;
		do @(posedge clk); while (!in_ready);
		extract_fields(b, eop);
		bytes_sent++;
		if (tx_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (records_due.size() != 0) @(posedge clk);
	endtask

	task automatic send_packet();
		foreach (pkt[i]) send_item(pkt[i], i == pkt.size() - 1);
		if (pkt.size() != 0) packets_sent++;
	endtask

	function automatic void add_random_bytes(input int n);
		repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void start_packet(input bit [15:0] msg);
		pkt.delete();
		add_random_bytes(16);
		pkt[12] = msg[15:8];
		pkt[13] = msg[7:0];
	endfunction

	function automatic void trim_packet(input int n);
		while (pkt.size() > n) void'(pkt.pop_back());
	endfunction

	function automatic void add_announce_body(input bit [7:0] slots, input bit pers_zero);
		add_random_bytes(39);
		pkt[52] = pers_zero ? 8'h00 : 8'($urandom_range(1, 255));
		pkt.push_back(slots);
		add_random_bytes(slots);
	endfunction

	function automatic void add_registry_prefix(input bit [7:0] count);
		add_random_bytes(2);
		pkt.push_back(count);
	endfunction

	function automatic void add_registry_entry(input bit [7:0] slots);
		add_random_bytes(39);
		pkt.push_back(slots);
		add_random_bytes(slots);
	endfunction

	task automatic test_short_packets();
		pkt.delete();
		pkt.push_back(8'hff);
		send_packet();
		pkt.delete();
		repeat (15) pkt.push_back(8'h00);
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_plain_headers();
		// header and end record from the same byte
		pkt.delete();
		repeat (16) pkt.push_back(8'hff);
		send_packet();
		pkt.delete();
		repeat (20) pkt.push_back(8'h00);
		send_packet();
		start_packet(16'h0300);
		add_random_bytes(30);
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_announce();
		start_packet(MSG_ANNOUNCE);
		add_announce_body(8'd3, 1'b0);
		add_random_bytes(2);
		send_packet();
		// node record and end record on byte 55
		start_packet(MSG_ANNOUNCE);
		add_announce_body(8'd0, 1'b1);
		send_packet();
		start_packet(MSG_ANNOUNCE);
		add_announce_body(8'd5, 1'b0);
		trim_packet(40);
		send_packet();
		start_packet(MSG_ANNOUNCE);
		add_announce_body(8'd255, 1'b1);
		trim_packet(66);
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_registry();
		start_packet(MSG_REGISTRY);
		add_registry_prefix(8'd3);
		add_registry_entry(8'd2);
		add_registry_entry(8'd0);
		add_registry_entry(8'd1);
		trim_packet(pkt.size() - 20);
		send_packet();
		// one declared entry, the second is ignored
		start_packet(MSG_REGISTRY);
		add_registry_prefix(8'd1);
		add_registry_entry(8'd1);
		add_registry_entry(8'd0);
		send_packet();
		start_packet(MSG_REGISTRY);
		add_registry_prefix(8'd0);
		send_packet();
		start_packet(MSG_REGISTRY);
		add_registry_prefix(8'd255);
		add_registry_entry(8'd0);
		add_registry_entry(8'd3);
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_random_traffic();
		int first_bytes;
		int sel;
		int n;
		first_bytes = bytes_sent;
		while (bytes_sent - first_bytes < RANDOM_BYTES) begin
			if (bytes_sent - first_bytes > RANDOM_BYTES * 82 / 100) quiet_tail = 1'b1;
			tx_gaps = ($urandom_range(0, 3) != 0);
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				start_packet(MSG_ANNOUNCE);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
				add_announce_body(8'(n), 1'($urandom_range(0, 1)));
				add_random_bytes($urandom_range(0, 3));
			end else if (sel < 80) begin
				start_packet(MSG_REGISTRY);
				n = $urandom_range(0, 2);
				add_registry_prefix(8'(n));
				if ($urandom_range(0, 4) == 0) n++;
				repeat (n) add_registry_entry(8'($urandom_range(0, 3)));
			end else if (sel < 90) begin
				start_packet(16'($urandom_range(0, 16'hffff)));
				add_random_bytes($urandom_range(0, 8));
			end else begin
				pkt.delete();
				add_random_bytes($urandom_range(1, 20));
			end
			if (sel < 80 && $urandom_range(0, 4) == 0) trim_packet($urandom_range(1, pkt.size()));
			send_packet();
			if (packets_sent % 25 == 0) hold_until_drained();
		end
		hold_until_drained();
	endtask

	initial begin
		restart_packet();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_packets();
		test_plain_headers();
		test_announce();
		test_registry();
		test_random_traffic();
		repeat (8) @(posedge clk);
		$display("sent %0d bytes in %0d packets, %0d records checked",
			bytes_sent, packets_sent, records_checked);
		$display("header %0d node %0d plca %0d registry %0d entry %0d end %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
			kind_seen[5]);
		if (mismatch_count == 0 && records_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: dncp_packet_field_extractor.f
+incdir+rtl/core
rtl/core/dncp_pfx_pkg.sv
rtl/core/dncp_pfx_parse.sv
rtl/core/dncp_pfx_outbuf.sv
rtl/core/dncp_packet_field_extractor.sv
rtl/core/dncp_pfx_checker.sv
tb/sv/dncp_packet_field_extractor_tb.sv
